>>> rtl/core/fasta_stream_parser_assert.svh
// Assertion macros used by the parser checker.
`ifndef FASTA_STREAM_PARSER_ASSERT_SVH
`define FASTA_STREAM_PARSER_ASSERT_SVH

// Clocked on clk, masked while rst_n is low.
`define FSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked on clk, also checked through reset.
`define FSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/fsp_pkg.sv
// Types, codes and helpers for the FASTA stream parser.
package fsp_pkg;

  localparam int LEN_W   = 32;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;

  localparam logic IN_DATA = 1'b0;
  localparam logic IN_END  = 1'b1;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] UPPER_MASK = 8'hDF;

  typedef enum logic [2:0] {
    K_CONTENT  = 3'd0,
    K_NAME     = 3'd1,
    K_NAME_END = 3'd2,
    K_RECORD   = 3'd3,
    K_ERROR    = 3'd4
  } out_kind_t;

  typedef enum logic [2:0] {
    E_EMPTY_AFTER_NAME = 3'd0,
    E_MULTI_NAME       = 3'd1,
    E_EMPTY_NAME       = 3'd2,
    E_BLANK_CONTENT    = 3'd3,
    E_SPACE            = 3'd4,
    E_NO_CONTENT       = 3'd5,
    E_OVERFLOW         = 3'd6
  } err_code_t;

  typedef enum logic [1:0] {
    PL_START   = 2'd0,
    PL_NAME    = 2'd1,
    PL_CONTENT = 2'd2,
    PL_BLANK   = 2'd3
  } prev_line_t;

  typedef enum logic [1:0] {
    LC_START   = 2'd0,
    LC_COMMENT = 2'd1,
    LC_NAME    = 2'd2,
    LC_CONTENT = 2'd3
  } line_class_t;

  typedef struct packed {
    out_kind_t        kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    err_code_t        code;
    logic             last;
  } result_t;

  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  function automatic result_t mk_res(out_kind_t k, logic [7:0] d, logic [LEN_W-1:0] l,
                                     err_code_t c);
    result_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    r.code = c;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/core/fsp_in_if.sv
// Input channel: one text byte or end-of-stream per request.
interface fsp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

>>> rtl/core/fsp_out_if.sv
// Result channel: one parser result per request.
interface fsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [31:0] record_length;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, out_kind, out_byte, record_length, error_code, last,
                  input ready);
  modport sink   (input valid, out_kind, out_byte, record_length, error_code, last,
                  output ready);
endinterface

>>> rtl/core/fasta_stream_parser.sv
// FASTA stream parser top level: config register, front end, queue, back end.
// Each result is registered in the pair queue before it is offered.
// Throughput: one input per cycle while the pair queue has room; an input with two
// results holds the output for both of them, absorbed by the two-entry pair queue.
// Reset (synchronous, rst_n low): parse state, error latch and queue cleared,
// fold_case set to 1; no clearing pass.
module fasta_stream_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  fsp_in_if.sink    in_chan,
  fsp_out_if.source out_chan
);
  import fsp_pkg::*;

  logic   fold_case_r;
  logic   q_ready, push, pop;
  entry_t push_entry;
  qhead_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) fold_case_r <= 1'b1;
    else if (cfg_wr_en) fold_case_r <= cfg_wr_data;
  end

  fsp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fold_case  (fold_case_r),
    .in_chan    (in_chan),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  fsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_ready    (q_ready),
    .head       (head)
  );

  fsp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .out_chan (out_chan),
    .pop      (pop)
  );

endmodule

>>> rtl/core/fsp_front.sv
// Front end: accepts bytes, tracks line and record state, builds result pairs.
module fsp_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fold_case,
  fsp_in_if.sink          in_chan,
  input  logic            q_ready,
  output logic            push,
  output fsp_pkg::entry_t push_entry
);
  import fsp_pkg::*;

  prev_line_t             prev_r, prev_nxt;
  line_class_t            cls_r, cls_nxt;
  logic [1:0]             nbs_r, nbs_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic                   err_r, err_nxt;

  logic       acc;
  logic [7:0] b;
  logic [1:0] n;
  result_t    r0, r1;

  logic       el_fail, el_nameend;
  err_code_t  el_code;
  prev_line_t el_prev;

  logic       cont_err;
  logic [7:0] cont_data;
  result_t    cont_res;

  logic [LEN_W-1:0] len_w;
  result_t          end_res;
  logic             end_ne;

  assign in_chan.ready = q_ready;
  assign acc = in_chan.valid && q_ready;
  assign b = in_chan.data_byte;
  assign len_w = LEN_W'(cnt_r);

  always_comb begin
    el_fail    = 1'b0;
    el_nameend = 1'b0;
    el_code    = E_EMPTY_AFTER_NAME;
    el_prev    = prev_r;
    case (cls_r)
      LC_START: begin
        if (prev_r == PL_NAME) el_fail = 1'b1;
        else el_prev = PL_BLANK;
      end
      LC_NAME: begin
        if (nbs_r == 2'd0) begin
          el_fail = 1'b1;
          el_code = E_EMPTY_NAME;
        end else begin
          el_nameend = 1'b1;
          el_prev    = PL_NAME;
        end
      end
      LC_CONTENT: el_prev = PL_CONTENT;
      default: ;
    endcase
  end

  always_comb begin
    cont_data = b;
    if (fold_case && (b inside {[CH_LOWER_A:CH_LOWER_Z]})) cont_data = b & UPPER_MASK;
    cont_err = 1'b1;
    if (b == CH_SPACE) cont_res = mk_res(K_ERROR, 8'd0, '0, E_SPACE);
    else if (&cnt_r) cont_res = mk_res(K_ERROR, 8'd0, '0, E_OVERFLOW);
    else begin
      cont_res = mk_res(K_CONTENT, cont_data, '0, E_EMPTY_AFTER_NAME);
      cont_err = 1'b0;
    end
  end

  always_comb begin
    prev_nxt = prev_r;
    cls_nxt  = cls_r;
    nbs_nxt  = nbs_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    end_res  = '0;
    end_ne   = 1'b0;

    if (in_chan.kind == IN_DATA) begin
      if (b == CH_LF) begin
        cls_nxt = LC_START;
        if (el_fail) begin
          r0      = mk_res(K_ERROR, 8'd0, '0, el_code);
          n       = 2'd1;
          err_nxt = 1'b1;
        end else begin
          prev_nxt = el_prev;
          if (el_nameend) begin
            r0 = mk_res(K_NAME_END, 8'd0, '0, E_EMPTY_AFTER_NAME);
            n  = 2'd1;
          end
        end
      end else begin
        case (cls_r)
          LC_START: begin
            if (b == CH_HASH) begin
              cls_nxt = LC_COMMENT;
            end else if (b == CH_GT) begin
              if (prev_r == PL_NAME) begin
                r0      = mk_res(K_ERROR, 8'd0, '0, E_MULTI_NAME);
                n       = 2'd1;
                err_nxt = 1'b1;
              end else begin
                cls_nxt = LC_NAME;
                nbs_nxt = 2'd0;
              end
            end else if (prev_r == PL_BLANK) begin
              r0      = mk_res(K_ERROR, 8'd0, '0, E_BLANK_CONTENT);
              n       = 2'd1;
              err_nxt = 1'b1;
            end else begin
              cls_nxt = LC_CONTENT;
              r0      = cont_res;
              n       = 2'd1;
              if (cont_err) err_nxt = 1'b1;
              else cnt_nxt = cnt_r + LENGTH_BITS'(1);
            end
          end
          LC_NAME: begin
            if (nbs_r != 2'd3) nbs_nxt = nbs_r + 2'd1;
            if (nbs_r == 2'd0 && cnt_r != '0) begin
              r0      = mk_res(K_RECORD, 8'd0, len_w, E_EMPTY_AFTER_NAME);
              r1      = mk_res(K_NAME, b, '0, E_EMPTY_AFTER_NAME);
              n       = 2'd2;
              cnt_nxt = '0;
            end else begin
              r0 = mk_res(K_NAME, b, '0, E_EMPTY_AFTER_NAME);
              n  = 2'd1;
            end
          end
          LC_CONTENT: begin
            r0 = cont_res;
            n  = 2'd1;
            if (cont_err) err_nxt = 1'b1;
            else cnt_nxt = cnt_r + LENGTH_BITS'(1);
          end
          default: ;
        endcase
      end
    end else begin
      if (cls_r != LC_START && el_fail) begin
        r0      = mk_res(K_ERROR, 8'd0, '0, el_code);
        n       = 2'd1;
        err_nxt = 1'b1;
      end else begin
        end_ne = (cls_r != LC_START) && el_nameend;
        if (cnt_r == '0) begin
          end_res = mk_res(K_ERROR, 8'd0, '0, E_NO_CONTENT);
          err_nxt = 1'b1;
        end else begin
          end_res  = mk_res(K_RECORD, 8'd0, len_w, E_EMPTY_AFTER_NAME);
          prev_nxt = PL_START;
          cls_nxt  = LC_START;
          nbs_nxt  = 2'd0;
          cnt_nxt  = '0;
        end
        if (end_ne) begin
          r0 = mk_res(K_NAME_END, 8'd0, '0, E_EMPTY_AFTER_NAME);
          r1 = end_res;
          n  = 2'd2;
        end else begin
          r0 = end_res;
          n  = 2'd1;
        end
      end
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  assign push             = acc && !err_r && (n != 2'd0);
  assign push_entry.r0    = r0;
  assign push_entry.r1    = r1;
  assign push_entry.two   = (n == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= PL_START;
      cls_r  <= LC_START;
      nbs_r  <= 2'd0;
      cnt_r  <= '0;
      err_r  <= 1'b0;
    end else if (acc && !err_r) begin
      prev_r <= prev_nxt;
      cls_r  <= cls_nxt;
      nbs_r  <= nbs_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

>>> rtl/core/fsp_queue.sv
// Two-entry queue of result pairs between front and back end.
module fsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fsp_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            q_ready,
  output fsp_pkg::qhead_t head
);
  import fsp_pkg::*;

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign q_ready    = (fill_r != (QPTR_W+1)'(QDEPTH));
  assign head.valid = (fill_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) fill_nxt = fill_r + 1'b1;
    else if (pop && !push) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  // depth is a power of two, pointers wrap naturally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_nxt;
    end
  end

endmodule

>>> rtl/core/fsp_back.sv
// Back end: sends each queued pair out as one or two result requests.
module fsp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fsp_pkg::qhead_t head,
  fsp_out_if.source       out_chan,
  output logic            pop
);
  import fsp_pkg::*;

  logic    phase_r, phase_nxt;
  logic    fire;
  result_t sel;

  assign sel  = phase_r ? head.entry.r1 : head.entry.r0;
  assign fire = head.valid && out_chan.ready;
  assign pop  = fire && (phase_r || !head.entry.two);

  assign out_chan.valid         = head.valid;
  assign out_chan.out_kind      = sel.kind;
  assign out_chan.out_byte      = sel.data;
  assign out_chan.record_length = sel.len;
  assign out_chan.error_code    = sel.code;
  assign out_chan.last          = sel.last;

  always_comb begin
    phase_nxt = phase_r;
    if (fire) phase_nxt = !phase_r && head.entry.two;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else phase_r <= phase_nxt;
  end

endmodule

>>> rtl/core/fsp_checker.sv
// Port-level assertions for the FASTA stream parser, bound to the top level.
`include "fasta_stream_parser_assert.svh"

module fsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [31:0] record_length,
  input logic [2:0]  error_code,
  input logic        last
);
  import fsp_pkg::*;

  logic        out_fire;
  logic        out_stall;
  logic        rec_mid;
  logic [46:0] out_word;

  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign rec_mid   = out_fire && out_kind == K_RECORD && !last;
  assign out_word  = {out_kind, out_byte, record_length, error_code, last};

  `FSP_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_word), "stalled result changed")
  `FSP_ASSERT(a_err_final, out_fire && out_kind == K_ERROR |=> !out_valid, "result after error")
  `FSP_ASSERT(a_rec_pair, rec_mid |=> out_valid && out_kind == K_NAME, "record end without name")
  `FSP_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind fasta_stream_parser fsp_checker u_fsp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_kind      (out_chan.out_kind),
  .out_byte      (out_chan.out_byte),
  .record_length (out_chan.record_length),
  .error_code    (out_chan.error_code),
  .last          (out_chan.last)
);
